// ----- hdl/lmm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lmm_pkg
// shared sizes and state codes for the list mean and median block
// ---------------------------------------------------------------------------
package lmm_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int DATA_W    = 32;
	localparam int SUM_W     = DATA_W + ADDR_W;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CLOSE,
		S_CAND_RD,
		S_CAND_WAIT,
		S_SWEEP,
		S_DRAIN,
		S_EVAL,
		S_WAIT,
		S_FIN
	} lmm_state_t;

	typedef struct packed {
		logic                     start;
		logic signed [SUM_W-1:0]  dividend;
		logic [CNT_W-1:0]         divisor;
	} lmm_div_req_t;

endpackage
`default_nettype wire

// ----- hdl/list_mean_median.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// list_mean_median
// loads a list of q16.16 values and reports count, mean and median
// ---------------------------------------------------------------------------
//  channel  ports                                               direction
//  in       in_valid in_stall sample last_item                  request in
//  out      out_valid out_stall mean_value median_value
//           item_count overflowed                               request out
//
//  elements load one per cycle into the element ram while in_stall is low
//  after the last element the median search reads the ram once per
//  candidate and once per compare
//  the mean divider runs in parallel with the search
//  the result sits in an output register; input stalls only from close of
//  a list until its result enters that register
//  reset clears counters and state; the ram needs no clearing
// ---------------------------------------------------------------------------
module list_mean_median
	import lmm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] sample,
	input  wire logic                     last_item,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      mean_value,
	output logic signed [DATA_W-1:0]      median_value,
	output logic [CNT_W-1:0]              item_count,
	output logic                          overflowed
);

	lmm_state_t state_q, state_nx;

	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         count_q;
	logic                     ovf_q;
	logic [CNT_W-1:0]         cand_idx_q;
	logic [CNT_W-1:0]         scan_idx_q;
	logic signed [DATA_W-1:0] cand_q;
	logic [CNT_W-1:0]         lt_cnt_q;
	logic [CNT_W-1:0]         le_cnt_q;
	logic                     rd_v_s1;
	logic signed [DATA_W-1:0] med_hi_q;
	logic signed [DATA_W-1:0] med_lo_q;
	logic                     out_valid_q;

	logic                     in_accept;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic                     rd_issue;
	logic                     out_free;
	logic                     fin_go;
	logic [CNT_W-1:0]         rank_hi;
	logic [CNT_W-1:0]         rank_lo;
	logic signed [DATA_W:0]   med_pair;
	logic signed [DATA_W-1:0] elem;
	logic                     div_busy;
	logic signed [DATA_W-1:0] div_quo;
	lmm_div_req_t             div_req;

	assign in_accept = in_valid && !in_stall;
	assign ram_we    = in_accept && (count_q != CNT_W'(MAX_ITEMS));
	assign out_free  = !out_valid_q || !out_stall;
	assign fin_go    = (state_q == S_FIN) && out_free;
	assign rank_hi   = count_q >> 1;
	assign rank_lo   = rank_hi - 1'b1;
	assign elem      = $signed(ram_rdata);
	assign med_pair  = (DATA_W+1)'(med_hi_q) + (DATA_W+1)'(med_lo_q);

	lmm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (sample),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign div_req.start    = (state_q == S_CLOSE);
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = count_q;

	lmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_accept && last_item) begin
					state_nx = S_CLOSE;
				end
			end
			S_CLOSE:     state_nx = S_CAND_RD;
			S_CAND_RD:   state_nx = S_CAND_WAIT;
			S_CAND_WAIT: state_nx = S_SWEEP;
			S_SWEEP: begin
				if (scan_idx_q == count_q - 1'b1) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN:     state_nx = S_EVAL;
			S_EVAL: begin
				if (cand_idx_q == count_q - 1'b1) begin
					state_nx = S_WAIT;
				end else begin
					state_nx = S_CAND_RD;
				end
			end
			S_WAIT: begin
				if (!div_busy) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_nx = S_LOAD;
				end
			end
			default:     state_nx = S_LOAD;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_stall  = 1'b1;
		rd_issue  = 1'b0;
		ram_raddr = cand_idx_q[ADDR_W-1:0];
		unique case (state_q)
			S_LOAD:    in_stall = 1'b0;
			S_CAND_RD: ram_raddr = cand_idx_q[ADDR_W-1:0];
			S_SWEEP: begin
				ram_raddr = scan_idx_q[ADDR_W-1:0];
				rd_issue  = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			sum_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			cand_idx_q  <= '0;
			scan_idx_q  <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_v_s1 <= rd_issue;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				if (ram_we) begin
					sum_q   <= sum_q + SUM_W'(sample);
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == S_CLOSE) begin
				cand_idx_q <= '0;
			end
			if (state_q == S_CAND_WAIT) begin
				scan_idx_q <= '0;
			end
			if (state_q == S_SWEEP) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (state_q == S_EVAL) begin
				cand_idx_q <= cand_idx_q + 1'b1;
			end
			if (fin_go) begin
				sum_q       <= '0;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	// rank counting for the current candidate
	always_ff @(posedge clk) begin
		if (state_q == S_CAND_WAIT) begin
			cand_q   <= elem;
			lt_cnt_q <= '0;
			le_cnt_q <= '0;
		end else if (rd_v_s1) begin
			if (elem < cand_q) begin
				lt_cnt_q <= lt_cnt_q + 1'b1;
			end
			if (elem <= cand_q) begin
				le_cnt_q <= le_cnt_q + 1'b1;
			end
		end
		if (state_q == S_EVAL) begin
			if (lt_cnt_q <= rank_hi && rank_hi < le_cnt_q) begin
				med_hi_q <= cand_q;
			end
			if (lt_cnt_q <= rank_lo && rank_lo < le_cnt_q) begin
				med_lo_q <= cand_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin_go) begin
			mean_value <= div_quo;
			item_count <= count_q;
			overflowed <= ovf_q;
			if (count_q[0]) begin
				median_value <= med_hi_q;
			end else begin
				median_value <= med_pair[DATA_W:1];
			end
		end
	end

	assign out_valid = out_valid_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("kept count beyond buffer depth");

	a_fin_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> count_q != '0)
		else $error("list closed with no kept element");

	a_div_idle_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> !div_busy)
		else $error("divider still busy while loading");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid && state_q == S_LOAD)
		else $error("finished result not presented");

endmodule
`default_nettype wire

// ----- hdl/lmm_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lmm_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module lmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/lmm_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lmm_div
// restoring signed divider, one quotient bit per cycle, rounds toward zero
// ---------------------------------------------------------------------------
module lmm_div
	import lmm_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lmm_div_req_t              req,
	output logic                           busy,
	output logic signed [DATA_W-1:0]       quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [CNT_W:0]    trial;
	logic [SUM_W-1:0]  quo_fix;

	assign trial = {rem_q, num_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
			neg_q <= req.dividend[SUM_W-1];
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= CNT_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo_fix  = neg_q ? SUM_W'(-quo_q) : quo_q;
	assign quotient = quo_fix[DATA_W-1:0];
	assign busy     = busy_q;

endmodule
`default_nettype wire

// ----- dv/list_mean_median_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// list_mean_median_test
// self-checking bench for the list mean and median block: a directed table
// (extreme values, rounding of negative halves) and a full and overflowing
// buffer precede random lists with random idle and stall phases; results are
// checked against table values or an in-bench model of the list statistics
// ---------------------------------------------------------------------------
module list_mean_median_test;
	import lmm_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] mean;
		logic signed [DATA_W-1:0] median;
		logic [CNT_W-1:0]         count;
		logic                     ovf;
	} stats_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     typed;
		stats_t                   stats;
	} row_t;

	localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] VMIN = 32'sh80000000;
	localparam int LIMIT = 2000000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     last_item = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] mean_value;
	logic signed [DATA_W-1:0] median_value;
	logic [CNT_W-1:0]         item_count;
	logic                     overflowed;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int requests = 0;
	int lists_checked = 0;
	int cycles = 0;

	// model of the list being loaded
	logic signed [DATA_W-1:0] kept[MAX_ITEMS];
	longint                   list_sum = 0;
	int                       list_len = 0;
	logic                     list_ovf = 1'b0;
	stats_t                   pending_stats[$];

	row_t dir_rows[$];

	list_mean_median uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("list_mean_median_test: errors");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	function automatic logic close_list(input logic signed [DATA_W-1:0] value,
		input logic last, output stats_t res);
		longint sorted[MAX_ITEMS];
		longint key;
		int j;
		if (list_len < MAX_ITEMS) begin
			kept[list_len] = value;
			list_sum += value;
			list_len++;
		end else begin
			list_ovf = 1'b1;
		end
		if (!last)
			return 1'b0;
		for (int i = 0; i < list_len; i++) begin
			key = kept[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		res.mean = DATA_W'(list_sum / list_len);
		if (list_len % 2)
			res.median = DATA_W'(sorted[list_len/2]);
		else
			res.median = DATA_W'((sorted[list_len/2] + sorted[list_len/2-1]) >>> 1);
		res.count = list_len[CNT_W-1:0];
		res.ovf = list_ovf;
		list_sum = 0;
		list_len = 0;
		list_ovf = 1'b0;
		return 1'b1;
	endfunction

	task automatic send(input row_t r);
		stats_t res;
		if (in_valid && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (in_valid == 1'b0 && $urandom_range(99) < idle_pct)
			@(posedge clk);
		in_valid <= 1'b1;
		sample <= r.value;
		last_item <= r.last;
		do @(posedge clk); while (in_stall);
		requests++;
		if (close_list(r.value, r.last, res))
			pending_stats.push_back(r.typed ? r.stats : res);
	endtask

	function automatic row_t mk(input logic signed [DATA_W-1:0] v, input logic l);
		mk = '0;
		mk.value = v;
		mk.last = l;
	endfunction

	function automatic row_t mkx(input logic signed [DATA_W-1:0] v,
		input logic signed [DATA_W-1:0] m, input logic signed [DATA_W-1:0] md,
		input int n);
		mkx = '0;
		mkx.value = v;
		mkx.last = 1'b1;
		mkx.typed = 1'b1;
		mkx.stats = '{m, md, n[CNT_W-1:0], 1'b0};
	endfunction

	function automatic logic signed [DATA_W-1:0] rnd_value();
		case ($urandom_range(9))
			0: rnd_value = VMAX - $urandom_range(3);
			1: rnd_value = VMIN + $urandom_range(3);
			2, 3: rnd_value = $signed($urandom_range(2000)) - 1000;
			default: rnd_value = $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		stats_t want;
		if (out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				report("unexpected result, count", item_count, 0);
			end else begin
				want = pending_stats.pop_front();
				lists_checked++;
				if (mean_value !== want.mean)
					report("mean", mean_value, want.mean);
				if (median_value !== want.median)
					report("median", median_value, want.median);
				if (item_count !== want.count)
					report("count", item_count, want.count);
				if (overflowed !== want.ovf)
					report("overflow", overflowed, want.ovf);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		int len;
		row_t r;
		dir_rows = '{
			mkx(VMAX, VMAX, VMAX, 1),
			mkx(VMIN, VMIN, VMIN, 1),
			mkx(32'sd0, 32'sd0, 32'sd0, 1),
			mk(VMAX, 1'b0), mkx(VMAX, VMAX, VMAX, 2),
			mk(VMIN, 1'b0), mkx(VMIN, VMIN, VMIN, 2),
			// sum of -1: mean rounds to zero, median floors to -1
			mk(VMAX, 1'b0), mkx(VMIN, 32'sd0, -32'sd1, 2),
			mk(-32'sd3, 1'b0), mkx(32'sd0, -32'sd1, -32'sd2, 2),
			mk(32'sd5, 1'b0), mk(-32'sd7, 1'b0), mk(32'sd100, 1'b0), mk(32'sd1, 1'b1),
			mk(32'sh00018000, 1'b0), mk(32'sh00010000, 1'b0), mk(-32'sh00020000, 1'b1),
			mk(32'sh55555555, 1'b0), mk(32'shaaaaaaaa, 1'b1)
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send(dir_rows[i]);
		// full buffer, then two dropped requests
		for (int i = 0; i < MAX_ITEMS + 2; i++)
			send(mk(rnd_value(), i == MAX_ITEMS + 1));
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 67 : (phase == 3) ? 34 : 0;
			stall_pct = (phase == 2) ? 67 : (phase == 3) ? 34 : 0;
			while (requests < 110 * (phase + 1)) begin
				case ($urandom_range(19))
					0: len = MAX_ITEMS;
					1: len = MAX_ITEMS + $urandom_range(1, 6);
					2, 3, 4: len = $urandom_range(9, 40);
					default: len = $urandom_range(1, 8);
				endcase
				for (int i = 0; i < len; i++) begin
					r = mk(rnd_value(), i == len - 1);
					send(r);
				end
			end
		end
		in_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d requests sent, %0d lists checked, incl. full and overflowing lists",
			requests, lists_checked);
		if (errors == 0)
			$display("list_mean_median_test: clean");
		else
			$display("list_mean_median_test: errors");
		$finish;
	end

endmodule
